/* src/sensor_reading_compensation_top_assert.svh */
// Assertion macros for the sensor reading compensation block.
// Used by the port checker; expects i_clk and i_rst_n in scope.
`ifndef SENSOR_READING_COMPENSATION_TOP_ASSERT_SVH
`define SENSOR_READING_COMPENSATION_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define SRC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define SRC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, live through reset
`define SRC_ASSERT_RAW_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/srcomp_pkg.sv */
// Package for the sensor reading compensation block: widths, register codes,
// coefficient struct and small arithmetic helpers. No dependencies.
package srcomp_pkg;

    localparam int RAW_T_W = 20;
    localparam int RAW_P_W = 20;
    localparam int RAW_H_W = 16;
    localparam int TEMP_W  = 16;
    localparam int HUM_W   = 10;
    localparam int PRESS_W = 32;
    localparam int CFG_W   = 64;
    localparam int ADDR_W  = 6;
    localparam int NUM_W   = 64;
    localparam int DEN_W   = 31;
    localparam int TAG_W   = TEMP_W + HUM_W;

    localparam logic [31:0] TF_HUM_OFFS  = 32'd76800;
    localparam logic [31:0] HUM_MAX      = 32'd419430400;
    localparam logic [32:0] TF_PRS_OFFS  = 33'd128000;
    localparam logic [20:0] PRS_FULL     = 21'd1048576;

    typedef enum logic [2:0] {
        REG_TEMP    = 3'd0,
        REG_PRESS_A = 3'd1,
        REG_PRESS_B = 3'd2,
        REG_PRESS_C = 3'd3,
        REG_HUM_A   = 3'd4,
        REG_HUM_B   = 3'd5,
        REG_PRESS_EN = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] c1;
        logic [15:0] c2;
        logic [15:0] c3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
        logic [7:0]  h1;
        logic [15:0] h2;
        logic [7:0]  h3;
        logic [11:0] h4;
        logic [11:0] h5;
        logic [7:0]  h6;
        logic        press_en;
    } t_coefs;

    function automatic logic [31:0] mul_lo32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = a * b;
        return p[31:0];
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
        logic signed [31:0] s;
        s = $signed(x) >>> n;
        return s;
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
        logic signed [63:0] s;
        s = $signed(x) >>> n;
        return s;
    endfunction

    function automatic logic [31:0] sx16_32(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sx12_32(input logic [11:0] v);
        return {{20{v[11]}}, v};
    endfunction

    function automatic logic [31:0] sx8_32(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

endpackage

/* src/srcomp_temp.sv */
// Temperature front end: three stages forming the fine temperature.
// Depends on srcomp_pkg.
module srcomp_temp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [srcomp_pkg::RAW_T_W-1:0]   i_raw_t,
    input  logic [srcomp_pkg::RAW_P_W-1:0]   i_raw_p,
    input  logic [srcomp_pkg::RAW_H_W-1:0]   i_raw_h,
    input  srcomp_pkg::t_coefs               i_coef,
    output logic                             o_valid,
    output logic [31:0]                      o_tf,
    output logic [srcomp_pkg::RAW_P_W-1:0]   o_raw_p,
    output logic [srcomp_pkg::RAW_H_W-1:0]   o_raw_h
);
    import srcomp_pkg::*;

    logic [2:0]         r_vld;
    logic [31:0]        r_m1, r_dd, r_v1, r_m2, r_tf;
    logic [RAW_P_W-1:0] r_rp [3];
    logic [RAW_H_W-1:0] r_rh [3];
    logic [31:0]        t1, d;

    always_comb begin
        t1 = {15'd0, i_raw_t[19:3]} - {15'd0, i_coef.c1, 1'b0};
        d  = {16'd0, i_raw_t[19:4]} - {16'd0, i_coef.c1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1  <= mul_lo32(t1, sx16_32(i_coef.c2));
            r_dd  <= mul_lo32(d, d);
            r_v1  <= asr32(r_m1, 11);
            r_m2  <= mul_lo32(asr32(r_dd, 12), sx16_32(i_coef.c3));
            r_tf  <= r_v1 + asr32(r_m2, 14);
            r_rp[0] <= i_raw_p;
            r_rp[1] <= r_rp[0];
            r_rp[2] <= r_rp[1];
            r_rh[0] <= i_raw_h;
            r_rh[1] <= r_rh[0];
            r_rh[2] <= r_rh[1];
        end
    end

    assign o_valid = r_vld[2];
    assign o_tf    = r_tf;
    assign o_raw_p = r_rp[2];
    assign o_raw_h = r_rh[2];
endmodule

/* src/srcomp_hum.sv */
// Humidity and temperature outputs: seven stages from the fine temperature.
// Depends on srcomp_pkg.
module srcomp_hum (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [31:0]                      i_tf,
    input  logic [srcomp_pkg::RAW_H_W-1:0]   i_raw_h,
    input  srcomp_pkg::t_coefs               i_coef,
    output logic                             o_valid,
    output logic [srcomp_pkg::TEMP_W-1:0]    o_temp,
    output logic [srcomp_pkg::HUM_W-1:0]     o_hum
);
    import srcomp_pkg::*;

    logic [6:0]        r_vld;
    logic [TEMP_W-1:0] r_tmp [7];
    logic [31:0]       r_xs, r_y, r_z, r_x [2], r_yz, r_wh, r_xw, r_hq2, r_hv5, r_h1m, r_hv6;
    logic [HUM_W-1:0]  r_hum;
    logic [31:0]       hv, tf5, y, z, w, hq, hv3, hvc;
    logic [19:0]       hs10;

    always_comb begin
        hv  = i_tf - TF_HUM_OFFS;
        tf5 = i_tf + {i_tf[29:0], 2'b00} + 32'd128;
        y   = asr32(r_y, 10);
        z   = asr32(r_z, 11) + 32'd32768;
        w   = asr32(r_wh + 32'd8192, 14);
        hq  = asr32(r_xw, 15);
        hv3 = r_hv6 - asr32(r_h1m, 4);
        if (hv3[31]) begin
            hvc = '0;
        end else if (hv3 > HUM_MAX) begin
            hvc = HUM_MAX;
        end else begin
            hvc = hv3;
        end
        hs10 = {3'd0, hvc[28:12]} * 20'd10;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xs   <= {2'd0, i_raw_h, 14'd0} - {i_coef.h4, 20'd0}
                      - mul_lo32(sx12_32(i_coef.h5), hv) + 32'd16384;
            r_y    <= mul_lo32(hv, sx8_32(i_coef.h6));
            r_z    <= mul_lo32(hv, {24'd0, i_coef.h3});
            r_tmp[0] <= tf5[23:8];
            r_x[0] <= asr32(r_xs, 15);
            r_yz   <= mul_lo32(y, z);
            r_x[1] <= r_x[0];
            r_wh   <= mul_lo32(asr32(r_yz, 10) + 32'd2097152, sx16_32(i_coef.h2));
            r_xw   <= mul_lo32(r_x[1], w);
            r_hq2  <= mul_lo32(hq, hq);
            r_hv5  <= r_xw;
            r_h1m  <= mul_lo32(asr32(r_hq2, 7), {24'd0, i_coef.h1});
            r_hv6  <= r_hv5;
            r_hum  <= hs10[19:10];
            for (int k = 1; k < 7; k++) begin
                r_tmp[k] <= r_tmp[k-1];
            end
        end
    end

    assign o_valid = r_vld[6];
    assign o_temp  = r_tmp[6];
    assign o_hum   = r_hum;
endmodule

/* src/srcomp_prs.sv */
// Pressure front end: seven stages forming the 64-bit dividend and 31-bit divisor.
// Depends on srcomp_pkg.
module srcomp_prs (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [31:0]                      i_tf,
    input  logic [srcomp_pkg::RAW_P_W-1:0]   i_raw_p,
    input  srcomp_pkg::t_coefs               i_coef,
    output logic [srcomp_pkg::NUM_W-1:0]     o_num,
    output logic [srcomp_pkg::DEN_W-1:0]     o_den
);
    import srcomp_pkg::*;

    logic signed [32:0] r_a;
    logic [20:0]        r_pn [5];
    logic [63:0]        r_aa;
    logic signed [48:0] r_ap5 [3], r_ap2 [3];
    logic signed [48:0] r_l6, r_l3;
    logic [31:0]        r_h6, r_h3;
    logic [63:0]        r_aap6, r_aap3, r_b, r_t, r_nb, r_num;
    logic [47:0]        r_tl;
    logic [31:0]        r_th;
    logic [DEN_W-1:0]   r_den;
    logic signed [65:0] aa_full;
    logic signed [48:0] ap5, ap2, l6, l3;
    logic [47:0]        tl;
    logic [63:0]        prod;

    always_comb begin
        aa_full = r_a * r_a;
        ap5     = r_a * $signed(i_coef.p5);
        ap2     = r_a * $signed(i_coef.p2);
        l6      = $signed({1'b0, r_aa[31:0]}) * $signed(i_coef.p6);
        l3      = $signed({1'b0, r_aa[31:0]}) * $signed(i_coef.p3);
        tl      = r_t[31:0] * i_coef.p1;
        prod    = {16'd0, r_tl} + {r_th, 32'd0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a      <= $signed({i_tf[31], i_tf}) - $signed(TF_PRS_OFFS);
            r_pn[0]  <= PRS_FULL - {1'b0, i_raw_p};
            r_aa     <= aa_full[63:0];
            r_ap5[0] <= ap5;
            r_ap2[0] <= ap2;
            r_l6     <= l6;
            r_l3     <= l3;
            r_h6     <= mul_lo32(r_aa[63:32], sx16_32(i_coef.p6));
            r_h3     <= mul_lo32(r_aa[63:32], sx16_32(i_coef.p3));
            r_aap6   <= {{15{r_l6[48]}}, r_l6} + {r_h6, 32'd0};
            r_aap3   <= {{15{r_l3[48]}}, r_l3} + {r_h3, 32'd0};
            r_b      <= r_aap6 + {r_ap5[2][46:0], 17'd0}
                        + {{13{i_coef.p4[15]}}, i_coef.p4, 35'd0};
            r_t      <= 64'h0000_8000_0000_0000 + asr64(r_aap3, 8)
                        + {{3{r_ap2[2][48]}}, r_ap2[2], 12'd0};
            r_tl     <= tl;
            r_th     <= mul_lo32(r_t[63:32], {16'd0, i_coef.p1});
            r_nb     <= {12'd0, r_pn[4], 31'd0} - r_b;
            r_den    <= prod[63:33];
            r_num    <= {r_nb[52:0], 11'd0} + {r_nb[53:0], 10'd0} + {r_nb[58:0], 5'd0}
                        + {r_nb[59:0], 4'd0} + {r_nb[61:0], 2'd0} + r_nb;
            for (int k = 1; k < 5; k++) begin
                r_pn[k] <= r_pn[k-1];
            end
            for (int k = 1; k < 3; k++) begin
                r_ap5[k] <= r_ap5[k-1];
                r_ap2[k] <= r_ap2[k-1];
            end
        end
    end

    assign o_num = r_num;
    assign o_den = r_den;
endmodule

/* src/srcomp_div.sv */
// Pipelined unsigned-magnitude divider, one quotient bit per stage, with
// sign and zero-divisor flags and a payload tag. Depends on srcomp_pkg.
module srcomp_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [srcomp_pkg::NUM_W-1:0]     i_num,
    input  logic [srcomp_pkg::DEN_W-1:0]     i_den,
    input  logic [srcomp_pkg::TAG_W-1:0]     i_tag,
    output logic                             o_valid,
    output logic [srcomp_pkg::NUM_W-1:0]     o_qmag,
    output logic                             o_neg,
    output logic                             o_dz,
    output logic [srcomp_pkg::TAG_W-1:0]     o_tag
);
    import srcomp_pkg::*;

    logic [NUM_W:0]   r_vld;
    logic [NUM_W:0]   r_neg, r_dz;
    logic [NUM_W-1:0] r_nq  [NUM_W+1];
    logic [DEN_W-1:0] r_rem [NUM_W+1];
    logic [DEN_W-1:0] r_md  [NUM_W+1];
    logic [TAG_W-1:0] r_tag [NUM_W+1];
    logic [DEN_W:0]   trial [NUM_W];
    logic [DEN_W:0]   diff  [NUM_W];
    logic [NUM_W-1:0] ge;

    always_comb begin
        for (int k = 0; k < NUM_W; k++) begin
            trial[k] = {r_rem[k], r_nq[k][NUM_W-1]};
            diff[k]  = trial[k] - {1'b0, r_md[k]};
            ge[k]    = trial[k] >= {1'b0, r_md[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NUM_W-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nq[0]  <= i_num[NUM_W-1] ? ({NUM_W{1'b0}} - i_num) : i_num;
            r_md[0]  <= i_den[DEN_W-1] ? ({DEN_W{1'b0}} - i_den) : i_den;
            r_rem[0] <= '0;
            r_neg[0] <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
            r_dz[0]  <= i_den == '0;
            r_tag[0] <= i_tag;
            for (int k = 0; k < NUM_W; k++) begin
                r_rem[k+1] <= ge[k] ? diff[k][DEN_W-1:0] : trial[k][DEN_W-1:0];
                r_nq[k+1]  <= {r_nq[k][NUM_W-2:0], ge[k]};
                r_md[k+1]  <= r_md[k];
                r_neg[k+1] <= r_neg[k];
                r_dz[k+1]  <= r_dz[k];
                r_tag[k+1] <= r_tag[k];
            end
        end
    end

    assign o_valid = r_vld[NUM_W];
    assign o_qmag  = r_nq[NUM_W];
    assign o_neg   = r_neg[NUM_W];
    assign o_dz    = r_dz[NUM_W];
    assign o_tag   = r_tag[NUM_W];
endmodule

/* src/srcomp_post.sv */
// Pressure back end: six stages from the quotient to the pre-scaled sum.
// Depends on srcomp_pkg.
module srcomp_post (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [srcomp_pkg::NUM_W-1:0]     i_qmag,
    input  logic                             i_neg,
    input  logic                             i_dz,
    input  logic [srcomp_pkg::TAG_W-1:0]     i_tag,
    input  srcomp_pkg::t_coefs               i_coef,
    output logic                             o_valid,
    output logic [63:0]                      o_sum,
    output logic                             o_dz,
    output logic [srcomp_pkg::TAG_W-1:0]     o_tag
);
    import srcomp_pkg::*;

    logic [5:0]         r_vld, r_dz;
    logic [TAG_W-1:0]   r_tag [6];
    logic [63:0]        r_q [5];
    logic [63:0]        r_sll, r_ss, r_p8p [3], r_p9ss, r_sum;
    logic [31:0]        r_slh, r_8h, r_9h;
    logic signed [48:0] r_8l, r_9l;
    logic [63:0]        s, sll;
    logic signed [48:0] l8, l9;

    always_comb begin
        s   = asr64(r_q[0], 13);
        sll = s[31:0] * s[31:0];
        l8  = $signed({1'b0, r_q[0][31:0]}) * $signed(i_coef.p8);
        l9  = $signed({1'b0, r_ss[31:0]}) * $signed(i_coef.p9);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0]   <= i_neg ? (64'd0 - i_qmag) : i_qmag;
            r_sll    <= sll;
            r_slh    <= mul_lo32(s[31:0], s[63:32]);
            r_8l     <= l8;
            r_8h     <= mul_lo32(r_q[0][63:32], sx16_32(i_coef.p8));
            r_ss     <= r_sll + {r_slh[30:0], 33'd0};
            r_p8p[0] <= {{15{r_8l[48]}}, r_8l} + {r_8h, 32'd0};
            r_9l     <= l9;
            r_9h     <= mul_lo32(r_ss[63:32], sx16_32(i_coef.p9));
            r_p8p[1] <= r_p8p[0];
            r_p9ss   <= {{15{r_9l[48]}}, r_9l} + {r_9h, 32'd0};
            r_p8p[2] <= r_p8p[1];
            r_sum    <= r_q[4] + asr64(r_p9ss, 25) + asr64(r_p8p[2], 19);
            r_dz[0]  <= i_dz;
            r_tag[0] <= i_tag;
            for (int k = 1; k < 5; k++) begin
                r_q[k] <= r_q[k-1];
            end
            for (int k = 1; k < 6; k++) begin
                r_dz[k]  <= r_dz[k-1];
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    assign o_valid = r_vld[5];
    assign o_sum   = r_sum;
    assign o_dz    = r_dz[5];
    assign o_tag   = r_tag[5];
endmodule

/* src/sensor_reading_compensation_top.sv */
// Top level of the sensor reading compensation block: configuration
// registers, pipeline enable, output register. Depends on srcomp_pkg and
// the srcomp_temp, srcomp_hum, srcomp_prs, srcomp_div, srcomp_post modules.
//
//  channel   direction  handshake                    payload
//  input     in         i_in_valid / o_in_stall      raw temperature, pressure, humidity
//  output    out        o_out_valid / i_out_stall    temperature, humidity, pressure
//  config    in         psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One reading enters per cycle while no result is stalled; the path is the 64-stage
// quotient pipeline (one bit per stage), the arithmetic stages and the output register.
// Reset is synchronous: clears valid bits, coefficients to 0, pressure enable to 1.
// A stalled result freezes the whole pipeline; o_in_stall follows that.
module sensor_reading_compensation_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [srcomp_pkg::RAW_T_W-1:0]   i_raw_temperature,
    input  logic [srcomp_pkg::RAW_P_W-1:0]   i_raw_pressure,
    input  logic [srcomp_pkg::RAW_H_W-1:0]   i_raw_humidity,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [srcomp_pkg::TEMP_W-1:0] o_temperature_centi,
    output logic [srcomp_pkg::HUM_W-1:0]     o_humidity_deci,
    output logic [srcomp_pkg::PRESS_W-1:0]   o_pressure_pa,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [srcomp_pkg::ADDR_W-1:0]    paddr,
    input  logic [srcomp_pkg::CFG_W-1:0]     pwdata,
    output logic [srcomp_pkg::CFG_W-1:0]     prdata,
    output logic                             pready
);
    import srcomp_pkg::*;

    logic [47:0]        r_temp_c, r_press_a, r_press_b, r_press_c;
    logic [31:0]        r_hum_a, r_hum_b;
    logic               r_press_en;
    logic               r_out_valid;
    logic [TEMP_W-1:0]  r_temp;
    logic [HUM_W-1:0]   r_hum;
    logic [PRESS_W-1:0] r_press;

    t_coefs             coef;
    t_reg_idx           idx;
    logic               en;
    logic               t_valid, h_valid, d_valid, p_valid;
    logic [31:0]        tf;
    logic [RAW_P_W-1:0] rp;
    logic [RAW_H_W-1:0] rh;
    logic [TEMP_W-1:0]  h_temp;
    logic [HUM_W-1:0]   h_hum;
    logic [NUM_W-1:0]   num, qmag;
    logic [DEN_W-1:0]   den;
    logic               q_neg, q_dz, p_dz;
    logic [TAG_W-1:0]   d_tag, p_tag;
    logic [63:0]        p_sum, v;

    assign idx  = t_reg_idx'(paddr[ADDR_W-1:3]);
    assign en   = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;
    assign pready = 1'b1;

    always_comb begin
        coef.c1 = r_temp_c[15:0];
        coef.c2 = r_temp_c[31:16];
        coef.c3 = r_temp_c[47:32];
        coef.p1 = r_press_a[15:0];
        coef.p2 = r_press_a[31:16];
        coef.p3 = r_press_a[47:32];
        coef.p4 = r_press_b[15:0];
        coef.p5 = r_press_b[31:16];
        coef.p6 = r_press_b[47:32];
        coef.p7 = r_press_c[15:0];
        coef.p8 = r_press_c[31:16];
        coef.p9 = r_press_c[47:32];
        coef.h1 = r_hum_a[7:0];
        coef.h2 = r_hum_a[23:8];
        coef.h3 = r_hum_a[31:24];
        coef.h4 = r_hum_b[11:0];
        coef.h5 = r_hum_b[23:12];
        coef.h6 = r_hum_b[31:24];
        coef.press_en = r_press_en;
    end

    always_comb begin
        unique case (idx)
            REG_TEMP:     prdata = {16'd0, r_temp_c};
            REG_PRESS_A:  prdata = {16'd0, r_press_a};
            REG_PRESS_B:  prdata = {16'd0, r_press_b};
            REG_PRESS_C:  prdata = {16'd0, r_press_c};
            REG_HUM_A:    prdata = {32'd0, r_hum_a};
            REG_HUM_B:    prdata = {32'd0, r_hum_b};
            REG_PRESS_EN: prdata = {63'd0, r_press_en};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_c    <= '0;
            r_press_a   <= '0;
            r_press_b   <= '0;
            r_press_c   <= '0;
            r_hum_a     <= '0;
            r_hum_b     <= '0;
            r_press_en  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                unique case (idx)
                    REG_TEMP:     r_temp_c   <= pwdata[47:0];
                    REG_PRESS_A:  r_press_a  <= pwdata[47:0];
                    REG_PRESS_B:  r_press_b  <= pwdata[47:0];
                    REG_PRESS_C:  r_press_c  <= pwdata[47:0];
                    REG_HUM_A:    r_hum_a    <= pwdata[31:0];
                    REG_HUM_B:    r_hum_b    <= pwdata[31:0];
                    REG_PRESS_EN: r_press_en <= pwdata[0];
                    default:      ;
                endcase
            end
            if (en) begin
                r_out_valid <= p_valid;
            end
        end
    end

    srcomp_temp u_temp (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(i_in_valid),
        .i_raw_t(i_raw_temperature), .i_raw_p(i_raw_pressure), .i_raw_h(i_raw_humidity),
        .i_coef(coef), .o_valid(t_valid), .o_tf(tf), .o_raw_p(rp), .o_raw_h(rh)
    );

    srcomp_hum u_hum (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(t_valid), .i_tf(tf), .i_raw_h(rh),
        .i_coef(coef), .o_valid(h_valid), .o_temp(h_temp), .o_hum(h_hum)
    );

    srcomp_prs u_prs (
        .i_clk, .i_en(en), .i_tf(tf), .i_raw_p(rp), .i_coef(coef),
        .o_num(num), .o_den(den)
    );

    srcomp_div u_div (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(h_valid), .i_num(num), .i_den(den),
        .i_tag({h_temp, h_hum}), .o_valid(d_valid), .o_qmag(qmag), .o_neg(q_neg),
        .o_dz(q_dz), .o_tag(d_tag)
    );

    srcomp_post u_post (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(d_valid), .i_qmag(qmag), .i_neg(q_neg),
        .i_dz(q_dz), .i_tag(d_tag), .i_coef(coef), .o_valid(p_valid), .o_sum(p_sum),
        .o_dz(p_dz), .o_tag(p_tag)
    );

    assign v = asr64(p_sum, 8) + {{44{coef.p7[15]}}, coef.p7, 4'd0};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_temp  <= p_tag[TAG_W-1:HUM_W];
            r_hum   <= p_tag[HUM_W-1:0];
            r_press <= (p_dz || !coef.press_en) ? '0 : v[39:8];
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_temperature_centi = r_temp;
    assign o_humidity_deci     = r_hum;
    assign o_pressure_pa       = r_press;
endmodule

/* src/srcomp_checker.sv */
// Port-level checker for sensor_reading_compensation_top, bound to it below.
// Depends on sensor_reading_compensation_top_assert.svh.
`include "sensor_reading_compensation_top_assert.svh"

module srcomp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_temperature_centi,
    input logic [9:0]  o_humidity_deci,
    input logic [31:0] o_pressure_pa
);
    `SRC_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_pressure_pa) && $stable(o_temperature_centi) && $stable(o_humidity_deci), "stalled transfer changed")
    `SRC_ASSERT_IMP(a_stall_follow, 1'b1, o_in_stall == (o_out_valid && i_out_stall), "input stall not tied to output stall")
    `SRC_ASSERT_RAW_NXT(a_reset_empty, !i_rst_n, !o_out_valid, "result valid after reset")
    `SRC_ASSERT_IMP(a_hum_range, o_out_valid, o_humidity_deci <= 10'd1000, "humidity above full scale")
endmodule

bind sensor_reading_compensation_top srcomp_checker u_chk (
    .i_clk, .i_rst_n, .o_in_stall, .o_out_valid, .i_out_stall,
    .o_temperature_centi, .o_humidity_deci, .o_pressure_pa
);
